@@ rtl/core/lru_kv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lru_kv_pkg;

   localparam int DEFAULT_ENTRIES = 16;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request opcodes
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [CAP_W-1:0]        cap_type;

endpackage

`default_nettype wire

@@ rtl/core/lru_key_value_cache_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// A get (req_type 0) returns the stored value on a hit; a put (req_type 1)
// updates an existing key or inserts a new one, evicting the least recent
// entry when the number of live entries has reached csr capacity (0 acts as
// 1, values above ENTRIES act as ENTRIES). Every request gives exactly one
// response. Throughput is one request per clock when the response side is
// not stalled: the key compare against all entries, the recency-rank update
// and the slot choice are done in a single pass between the input register
// and the response register. The store is empty after reset and needs no
// clearing time. The user must write capacity only while no request is in
// flight; the block itself does not enforce this.
module lru_key_value_cache_top #(
   parameter int ENTRIES = lru_kv_pkg::DEFAULT_ENTRIES
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                csr_wr_en,
   input  wire lru_kv_pkg::cap_type csr_wr_data,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_type,
   input  wire lru_kv_pkg::key_type req_key,
   input  wire lru_kv_pkg::val_type req_value,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_hit,
   output lru_kv_pkg::val_type      rsp_read_value,
   output logic                     rsp_evicted
);

   import lru_kv_pkg::*;

   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef logic [AGE_W-1:0]   age_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ENTRIES-1:0] vec_type;

   // configuration
   cap_type capacity_ff;

   // input register
   logic    in_valid_ff;
   logic    in_type_ff;
   key_type in_key_ff;
   val_type in_value_ff;

   // entry store
   key_type keys_ff   [ENTRIES];
   val_type values_ff [ENTRIES];
   age_type age_ff    [ENTRIES];
   vec_type valid_ff;
   cnt_type live_count_ff;

   key_type keys_in   [ENTRIES];
   val_type values_in [ENTRIES];
   age_type age_in    [ENTRIES];
   vec_type valid_in;
   cnt_type live_count_in;

   // response register
   logic    rsp_valid_ff;
   logic    rsp_hit_ff;
   val_type rsp_read_value_ff;
   logic    rsp_evicted_ff;

   logic    rsp_hit_in;
   val_type rsp_read_value_in;
   logic    rsp_evicted_in;

   logic    out_free;
   logic    fire;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // lookup and update logic
   vec_type          match;
   vec_type          evict;
   vec_type          valid_after;
   vec_type          slot_oh;
   logic             hit;
   logic             is_put;
   logic             need_evict;
   logic             insert;
   val_type          hit_value;
   age_type          hit_age;
   age_type          oldest_age;
   cnt_type          live_m1;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] eff_cap;

   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign live_m1    = live_count_ff - CNT_W'(1);
   assign oldest_age = live_m1[AGE_W-1:0];
   assign is_put     = (in_type_ff == REQ_PUT);

   always_comb begin
      hit_value = '0;
      hit_age   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (keys_ff[i] == in_key_ff);
         if (match[i]) begin
            hit_value = hit_value | values_ff[i];
            hit_age   = hit_age | age_ff[i];
         end
      end
   end

   assign hit        = |match;
   assign need_evict = !hit && is_put && (CMP_W'(live_count_ff) >= eff_cap);
   assign insert     = !hit && is_put;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         evict[i] = need_evict && valid_ff[i] && (age_ff[i] == oldest_age);
      end
   end

   assign valid_after = valid_ff & ~evict;
   // lowest free slot, one-hot
   assign slot_oh     = ~valid_after & (valid_after + vec_type'(1));

   always_comb begin
      valid_in      = valid_ff;
      live_count_in = live_count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         keys_in[i]   = keys_ff[i];
         values_in[i] = values_ff[i];
         age_in[i]    = age_ff[i];
      end

      if (hit) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
               age_in[i] = '0;
               if (is_put) begin
                  values_in[i] = in_value_ff;
               end
            end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
               age_in[i] = age_ff[i] + 1'b1;
            end
         end
      end else if (insert) begin
         valid_in = valid_after | slot_oh;
         if (!need_evict) begin
            live_count_in = live_count_ff + CNT_W'(1);
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_oh[i]) begin
               keys_in[i]   = in_key_ff;
               values_in[i] = in_value_ff;
               age_in[i]    = '0;
            end else if (valid_after[i]) begin
               age_in[i] = age_ff[i] + 1'b1;
            end
         end
      end

      rsp_hit_in        = hit;
      rsp_read_value_in = (hit && !is_put) ? hit_value : '0;
      rsp_evicted_in    = need_evict;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         in_valid_ff   <= 1'b0;
         valid_ff      <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            valid_ff      <= valid_in;
            live_count_ff <= live_count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff  <= req_type;
         in_key_ff   <= req_key;
         in_value_ff <= req_value;
      end
      if (fire) begin
         for (int i = 0; i < ENTRIES; i++) begin
            keys_ff[i]   <= keys_in[i];
            values_ff[i] <= values_in[i];
         end
         rsp_hit_ff        <= rsp_hit_in;
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_evicted_ff    <= rsp_evicted_in;
      end
   end

   // recency ranks are only meaningful on live entries, but keep them reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (fire) begin
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule

`default_nettype wire

@@ test/lru_key_value_cache_top_tb.sv @@
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;
   import lru_kv_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_SEGMENTS = 8;
   localparam int SEGMENT_ITEMS = 250;

   typedef struct packed {
      logic    hit;
      val_type read_value;
      logic    evicted;
   } cache_rsp_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en = 1'b0;
   cap_type csr_wr_data = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   logic    req_type = REQ_GET;
   key_type req_key = '0;
   val_type req_value = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   logic    rsp_hit;
   val_type rsp_read_value;
   logic    rsp_evicted;

   lru_key_value_cache_top #(.ENTRIES(ENTRIES)) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value),
      .rsp_evicted(rsp_evicted)
   );

   always #1 clock = ~clock;

   // predicted cache contents
   key_type     line_key[ENTRIES];
   val_type     line_val[ENTRIES];
   bit          line_live[ENTRIES];
   int unsigned line_rank[ENTRIES];
   int          live_lines = 0;
   cap_type     cap_reg = CAP_RESET;

   cache_rsp_type pending_rsp_q[$];

   // traffic shaping
   int burst_left = 0;
   int burst_max = 1;
   int gap_max = 0;
   int stall_run_max = 0;
   int go_run_max = 1;
   int holdoff_request = 0;
   int holdoff_left = 0;
   int stall_phase_left = 0;
   bit in_stall = 1'b0;

   key_type key_pool[24];
   int      pool_n = 1;

   // bookkeeping
   int cycle_count = 0;
   int mismatch_count = 0;
   int rsp_count = 0;
   int get_count = 0;
   int put_count = 0;
   int hit_count = 0;
   int evict_count = 0;
   int cap_writes = 0;
   int holdoffs = 0;

   function automatic int usable_lines();
      int c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
   endfunction

   // make line s most recent; a line not yet live counts as older than all
   function automatic void promote(int s);
      int unsigned old_rank;
      old_rank = line_live[s] ? line_rank[s] : 32'hFFFF_FFFF;
      for (int i = 0; i < ENTRIES; i++) begin
         if (i != s && line_live[i] && line_rank[i] < old_rank) line_rank[i]++;
      end
      line_rank[s] = 0;
   endfunction

   function automatic cache_rsp_type lru_access(logic op, key_type k, val_type v);
      cache_rsp_type r;
      int found;
      int oldest;
      int slot;
      r.hit = 1'b0;
      r.read_value = '0;
      r.evicted = 1'b0;
      found = -1;
      oldest = -1;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && line_live[i] && line_key[i] == k) found = i;
      end
      if (found >= 0) begin
         r.hit = 1'b1;
         if (op == REQ_PUT) line_val[found] = v;
         else r.read_value = line_val[found];
         promote(found);
      end else if (op == REQ_PUT) begin
         if (live_lines >= usable_lines()) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (line_live[i] && (oldest < 0 || line_rank[i] > line_rank[oldest]))
                  oldest = i;
            end
            if (oldest >= 0) begin
               line_live[oldest] = 1'b0;
               if (live_lines > 0) live_lines--;
               r.evicted = 1'b1;
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !line_live[i]) slot = i;
         end
         if (slot >= 0) begin
            line_key[slot] = k;
            line_val[slot] = v;
            promote(slot);
            line_live[slot] = 1'b1;
            live_lines++;
         end
      end
      return r;
   endfunction

   // entered and left at a falling edge
   task automatic send_request(logic op, key_type k, val_type v);
      int gap;
      cache_rsp_type r;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_valid = 1'b1;
      req_type = op;
      req_key = k;
      req_value = v;
      do @(posedge clock); while (req_stall);
      r = lru_access(op, k, v);
      pending_rsp_q.push_back(r);
      if (op == REQ_PUT) put_count++;
      else get_count++;
      if (r.hit) hit_count++;
      if (r.evicted) evict_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_responses();
      req_valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_capacity(cap_type c);
      wait_for_responses();
      csr_wr_en = 1'b1;
      csr_wr_data = c;
      @(posedge clock);
      cap_reg = c;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cap_writes++;
   endtask

   task automatic set_idle_profile(int kind);
      case (kind)
         0: begin
            gap_max = 0; burst_max = 1; stall_run_max = 0; go_run_max = 1;
         end
         1: begin
            gap_max = 3; burst_max = 8; stall_run_max = 2; go_run_max = 6;
         end
         default: begin
            gap_max = 8; burst_max = 3; stall_run_max = 6; go_run_max = 3;
         end
      endcase
      burst_left = 0;
   endtask

   task automatic refill_key_pool();
      pool_n = usable_lines() + $urandom_range(0, 4);
      for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
      case ($urandom_range(0, 3))
         0: key_pool[0] = 32'sh8000_0000;
         1: key_pool[0] = 32'sh7FFF_FFFF;
         default: ;
      endcase
   endtask

   function automatic key_type pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, pool_n - 1)];
   endfunction

   function automatic cap_type capacity_for_segment(int seg);
      case (seg)
         0: return 5'd16;
         1: return 5'd1;
         2: return 5'd31;
         3: return 5'd0;
         4: return 5'd7;
         5: return 5'd2;
         6: return 5'd16;
         default: return cap_type'($urandom_range(0, 31));
      endcase
   endfunction

   // lookups on the empty store, including the extreme keys
   task automatic test_get_on_empty_store();
      set_idle_profile(1);
      send_request(REQ_GET, 32'sh0000_0000, 32'sh1234_5678);
      send_request(REQ_GET, 32'sh8000_0000, '0);
      send_request(REQ_GET, 32'sh7FFF_FFFF, '0);
   endtask

   task automatic test_put_and_update();
      send_request(REQ_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_request(REQ_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_request(REQ_PUT, 32'sh0000_0000, -32'sd1);
      send_request(REQ_PUT, -32'sd1, 32'sh0000_0000);
      send_request(REQ_GET, 32'sh8000_0000, -32'sd1);
      send_request(REQ_GET, 32'sh7FFF_FFFF, '0);
      send_request(REQ_GET, 32'sh0000_0000, '0);
      send_request(REQ_GET, -32'sd1, '0);
      // put on a present key refreshes and overwrites
      send_request(REQ_PUT, 32'sh0000_0000, 32'sd5);
      send_request(REQ_GET, 32'sh0000_0000, '0);
   endtask

   // capacity dropped below the live count: each new put evicts one
   task automatic test_capacity_shrink();
      write_capacity(5'd2);
      send_request(REQ_PUT, 32'sh0000_1111, 32'sh0000_2222);
      send_request(REQ_PUT, 32'sh0000_3333, 32'sh0000_4444);
      send_request(REQ_GET, 32'sh8000_0000, '0);
      send_request(REQ_GET, 32'sh7FFF_FFFF, '0);
   endtask

   task automatic test_capacity_extremes();
      write_capacity(5'd0);
      send_request(REQ_PUT, 32'sh5555_AAAA, 32'shAAAA_5555);
      send_request(REQ_GET, 32'sh5555_AAAA, '0);
      write_capacity(5'd31);
      send_request(REQ_PUT, 32'sh0F0F_F0F0, 32'shF0F0_0F0F);
      write_capacity(5'd1);
      send_request(REQ_PUT, 32'sh1357_9BDF, 32'sd1);
      send_request(REQ_PUT, 32'sh2468_ACE0, 32'sd2);
      send_request(REQ_GET, 32'sh1357_9BDF, '0);
   endtask

   // response side holds off while requests keep coming, then a full drain
   task automatic test_response_holdoff();
      write_capacity(5'd4);
      set_idle_profile(0);
      refill_key_pool();
      holdoff_request = 200;
      holdoffs++;
      for (int n = 0; n < 40; n++)
         send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, pick_key(), $urandom);
      wait_for_responses();
   endtask

   task automatic test_random_traffic();
      for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
         write_capacity(capacity_for_segment(seg));
         set_idle_profile(seg % 3);
         refill_key_pool();
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if (seg == 4 && n == 100) begin
               holdoff_request = 150;
               holdoffs++;
            end
            if (seg == 5 && n == 125) wait_for_responses();
            send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, pick_key(), $urandom);
         end
      end
   endtask

   // response stall pattern, with long hold-offs on request
   always @(negedge clock) begin
      if (holdoff_request != 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left != 0) begin
         rsp_stall = 1'b1;
         holdoff_left--;
      end else if (stall_run_max == 0) begin
         rsp_stall = 1'b0;
      end else begin
         if (stall_phase_left == 0) begin
            in_stall = !in_stall;
            stall_phase_left = in_stall ? $urandom_range(1, stall_run_max)
                                        : $urandom_range(1, go_run_max);
         end
         stall_phase_left--;
         rsp_stall = in_stall;
      end
   end

   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         rsp_count++;
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("rsp %0d with none outstanding: hit=%0b val=%0d ev=%0b",
                        rsp_count, rsp_hit, rsp_read_value, rsp_evicted);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_hit !== want.hit || rsp_read_value !== want.read_value ||
                rsp_evicted !== want.evicted) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("rsp %0d: exp hit=%0b val=%0d ev=%0b, got hit=%0b val=%0d ev=%0b",
                           rsp_count, want.hit, want.read_value, want.evicted,
                           rsp_hit, rsp_read_value, rsp_evicted);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_rsp_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         line_key[i] = '0;
         line_val[i] = '0;
         line_live[i] = 1'b0;
         line_rank[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_get_on_empty_store();
      test_put_and_update();
      test_capacity_shrink();
      test_capacity_extremes();
      test_response_holdoff();
      test_random_traffic();

      wait_for_responses();
      repeat (8) @(posedge clock);

      if (pending_rsp_q.size() != 0)
         $display("%0d responses never arrived", pending_rsp_q.size());
      $display("covered %0d requests (%0d gets, %0d puts): %0d hits, %0d evictions",
               get_count + put_count, get_count, put_count, hit_count, evict_count);
      $display("%0d capacity writes, %0d long response hold-offs, %0d mismatches",
               cap_writes, holdoffs, mismatch_count);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
